// ===== rtl/rfv_pkg.sv =====
// Package for the record frame validator: record layout constants, status
// codes, the queue item type and the FNV-1a step function.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rfv_pkg;

  // Record header layout and format constants.
  localparam int unsigned HEADER_BYTES        = 24;
  localparam int unsigned HDR_SUM_FIRST       = 20;
  localparam logic [31:0] REC_MAGIC           = 32'h5352_4631;
  localparam logic [15:0] REC_VERSION         = 16'd1;
  localparam logic [15:0] REC_HDR_SIZE        = 16'd24;

  // FNV-1a 32-bit constants.
  localparam logic [31:0] FNV_BASIS           = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME           = 32'd16777619;

  // Widths of the limit register and the payload byte counter.
  localparam int unsigned LIMIT_W             = 13;
  localparam int unsigned CNT_W               = 14;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd4096;
  localparam int unsigned DEFAULT_MAX_PAYLOAD = 4096;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH         = 2;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED     = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM      = 2'd2;

  // One classified byte, as the front hands it to the back.
  typedef struct packed {
    logic [7:0] data;       // the byte itself
    logic       last;       // final byte of the record
    logic       hdr;        // byte belongs to the header
    logic [4:0] hidx;       // header byte index when hdr is set
    logic       pay;        // byte falls within the declared payload
    logic       pay_end;    // byte is the final declared payload byte
    logic       trail;      // byte lies past the declared payload
    logic       hdr_done;   // all header bytes seen, this one included
    logic       pay_short;  // payload still incomplete after this byte
  } rfv_item_t;

  // One FNV-1a step: xor the byte in, multiply by the prime modulo 2^32.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * FNV_PRIME);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rfv_queue.sv =====
// Short first-in first-out queue of classified bytes between the front and
// the back of the record frame validator. Depends on rfv_pkg.
`default_nettype none

module rfv_queue #(
  parameter int unsigned DEPTH = rfv_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rfv_pkg::rfv_item_t push_item,
  output logic                   not_full,
  input  wire logic              pop,
  output logic                   not_empty,
  output rfv_pkg::rfv_item_t     head_item
);
  import rfv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  rfv_item_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;

  assign not_full  = (count_r != CNT_QW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfv_front.sv =====
// Front of the record frame validator: accepts byte requests and classifies
// each one as header, payload or trailing byte. Depends on rfv_pkg.
`default_nettype none

module rfv_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_last_byte,
  input  wire logic          q_not_full,
  output logic               push,
  output rfv_pkg::rfv_item_t push_item
);
  import rfv_pkg::*;

  logic [4:0]       hcnt_r, hcnt_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [CNT_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic             is_hdr;
  logic             is_pay;
  logic [CNT_W-1:0] cnt_after;

  assign in_ready = q_not_full;
  assign push     = in_valid && q_not_full;

  // Classification of the byte against the position in the record.
  always_comb begin
    is_hdr    = (hcnt_r < 5'(HEADER_BYTES));
    is_pay    = !is_hdr && ({{(32 - CNT_W){1'b0}}, pay_cnt_r} < len_r);
    cnt_after = (is_pay && (pay_cnt_r != '1)) ? pay_cnt_r + 1'b1 : pay_cnt_r;

    push_item.data      = in_data_byte;
    push_item.last      = in_last_byte;
    push_item.hdr       = is_hdr;
    push_item.hidx      = hcnt_r;
    push_item.pay       = is_pay;
    push_item.pay_end   = is_pay && ({{(32 - CNT_W){1'b0}}, cnt_after} == len_r);
    push_item.trail     = !is_hdr && !is_pay;
    push_item.hdr_done  = !is_hdr || (hcnt_r == 5'(HEADER_BYTES - 1));
    push_item.pay_short = ({{(32 - CNT_W){1'b0}}, cnt_after} < len_r);
  end

  // Position tracking; the length field is picked up as it passes.
  always_comb begin
    hcnt_nxt    = hcnt_r;
    len_nxt     = len_r;
    pay_cnt_nxt = pay_cnt_r;
    if (push) begin
      if (in_last_byte) begin
        hcnt_nxt    = '0;
        len_nxt     = '0;
        pay_cnt_nxt = '0;
      end else if (is_hdr) begin
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r[4:2] == 3'd3) begin
          len_nxt[{hcnt_r[1:0], 3'b000} +: 8] = in_data_byte;
        end
      end else begin
        pay_cnt_nxt = cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r    <= '0;
      len_r     <= '0;
      pay_cnt_r <= '0;
    end else begin
      hcnt_r    <= hcnt_nxt;
      len_r     <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfv_back.sv =====
// Back of the record frame validator: hashes header and payload, assembles
// the header fields, tracks the first failure and registers the result.
// Depends on rfv_pkg.
`default_nettype none

module rfv_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_not_empty,
  input  wire rfv_pkg::rfv_item_t         q_item,
  output logic                            pop,
  input  wire logic [rfv_pkg::LIMIT_W-1:0] limit,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [31:0]                     out_sequence_res,
  output logic [rfv_pkg::LIMIT_W-1:0]     out_payload_length
);
  import rfv_pkg::*;

  logic [31:0] hh_r, hh_nxt;
  logic [31:0] ph_r, ph_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [15:0] hsize_r, hsize_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] eps_r, eps_nxt;
  logic [31:0] ehs_r, ehs_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [1:0]  err_fin;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [31:0] seq_out_r;
  logic [LIMIT_W-1:0] len_out_r;

  logic [7:0]  hash_byte;
  logic [31:0] hh_step;
  logic [31:0] ph_step;
  logic [LIMIT_W-1:0] len_clamp;
  logic        load_out;

  // An item moves on unless it carries a result that has nowhere to go.
  assign pop      = q_not_empty && (!q_item.last || !out_valid_r || out_ready);
  assign load_out = pop && q_item.last;

  // The header checksum field is hashed as zero bytes.
  assign hash_byte = (q_item.hidx >= 5'(HDR_SUM_FIRST)) ? 8'd0 : q_item.data;
  assign hh_step   = fnv_step(hh_r, hash_byte);
  assign ph_step   = fnv_step(ph_r, q_item.data);

  // Header assembly, hashing and first-failure tracking.
  always_comb begin
    hh_nxt    = hh_r;
    ph_nxt    = ph_r;
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    hsize_nxt = hsize_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    eps_nxt   = eps_r;
    ehs_nxt   = ehs_r;
    err_nxt   = err_r;

    if (q_item.hdr) begin
      hh_nxt = hh_step;
      case (q_item.hidx[4:2])
        3'd0: magic_nxt[{q_item.hidx[1:0], 3'b000} +: 8] = q_item.data;
        3'd1: begin
          if (!q_item.hidx[1]) begin
            ver_nxt[{q_item.hidx[0], 3'b000} +: 8] = q_item.data;
          end else begin
            hsize_nxt[{q_item.hidx[0], 3'b000} +: 8] = q_item.data;
          end
        end
        3'd2: seq_nxt[{q_item.hidx[1:0], 3'b000} +: 8] = q_item.data;
        3'd3: len_nxt[{q_item.hidx[1:0], 3'b000} +: 8] = q_item.data;
        3'd4: eps_nxt[{q_item.hidx[1:0], 3'b000} +: 8] = q_item.data;
        default: ehs_nxt[{q_item.hidx[1:0], 3'b000} +: 8] = q_item.data;
      endcase
      // Header checks once the last header byte is in.
      if ((q_item.hidx == 5'(HEADER_BYTES - 1)) && (err_r == STATUS_OK)) begin
        if ((magic_nxt != REC_MAGIC) || (ver_nxt != REC_VERSION) ||
            (hsize_nxt != REC_HDR_SIZE) ||
            (len_nxt > {{(32 - LIMIT_W){1'b0}}, limit})) begin
          err_nxt = STATUS_MALFORMED;
        end else if (hh_nxt != ehs_nxt) begin
          err_nxt = STATUS_CHECKSUM;
        end else if ((len_nxt == '0) && (ph_r != eps_nxt)) begin
          err_nxt = STATUS_CHECKSUM;
        end
      end
    end else if (err_r == STATUS_OK) begin
      if (q_item.pay) begin
        ph_nxt = ph_step;
        if (q_item.pay_end && (ph_step != eps_r)) begin
          err_nxt = STATUS_CHECKSUM;
        end
      end else if (q_item.trail) begin
        err_nxt = STATUS_MALFORMED;
      end
    end
  end

  // Final status and the reported length for a record that ends here.
  always_comb begin
    err_fin = err_nxt;
    if ((err_nxt == STATUS_OK) && (!q_item.hdr_done || q_item.pay_short)) begin
      err_fin = STATUS_MALFORMED;
    end
    if (len_nxt > {{(32 - LIMIT_W){1'b0}}, limit}) begin
      len_clamp = limit;
    end else begin
      len_clamp = len_nxt[LIMIT_W-1:0];
    end
  end

  // Record state; it starts over after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || load_out) begin
      hh_r    <= FNV_BASIS;
      ph_r    <= FNV_BASIS;
      magic_r <= '0;
      ver_r   <= '0;
      hsize_r <= '0;
      seq_r   <= '0;
      len_r   <= '0;
      eps_r   <= '0;
      ehs_r   <= '0;
      err_r   <= STATUS_OK;
    end else if (pop) begin
      hh_r    <= hh_nxt;
      ph_r    <= ph_nxt;
      magic_r <= magic_nxt;
      ver_r   <= ver_nxt;
      hsize_r <= hsize_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      eps_r   <= eps_nxt;
      ehs_r   <= ehs_nxt;
      err_r   <= err_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r  <= err_fin;
      seq_out_r <= q_item.hdr_done ? seq_nxt : '0;
      len_out_r <= q_item.hdr_done ? len_clamp : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_sequence_res   = seq_out_r;
  assign out_payload_length = len_out_r;

endmodule

`default_nettype wire

// ===== rtl/record_frame_validator.sv =====
// Record frame validator: one record byte per request, one result request
// on the final byte. Throughput is one byte per clock while the queue has
// room, with one FNV-1a multiply per byte in the back. A result is registered
// once its final byte leaves the queue; a two-entry queue lets the input run
// on while a result waits. Synchronous active-low reset clears all record
// state and sets the payload limit register to 4096; no clearing pass is needed.
// Depends on rfv_pkg, rfv_front, rfv_queue and rfv_back.
`default_nettype none

module record_frame_validator #(
  parameter int unsigned MAX_PAYLOAD_BYTES = rfv_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_last_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [31:0]                      out_sequence_res,
  output logic [rfv_pkg::LIMIT_W-1:0]      out_payload_length,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rfv_pkg::LIMIT_W-1:0] cfg_payload_limit
);
  import rfv_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] limit_eff;
  logic               q_not_full;
  logic               q_not_empty;
  logic               push;
  logic               pop;
  rfv_item_t          push_item;
  rfv_item_t          head_item;

  // Payload limit register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_payload_limit;
    end
  end

  // The limit in force is the smaller of the register and the build maximum.
  assign limit_eff = ({{(32 - LIMIT_W){1'b0}}, limit_r} > 32'(MAX_PAYLOAD_BYTES)) ?
                     LIMIT_W'(MAX_PAYLOAD_BYTES) : limit_r;

  rfv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_not_full   (q_not_full),
    .push         (push),
    .push_item    (push_item)
  );

  rfv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  rfv_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_item             (head_item),
    .pop                (pop),
    .limit              (limit_eff),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length)
  );

endmodule

`default_nettype wire

// ===== rtl/rfv_checker.sv =====
// Port-level checks for the record frame validator, attached by bind.
// Depends on rfv_pkg and the record_frame_validator top level.
`default_nettype none

module rfv_checker #(
  parameter int unsigned MAX_PAYLOAD_BYTES = rfv_pkg::DEFAULT_MAX_PAYLOAD
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_status,
  input wire logic [31:0]                 out_sequence_res,
  input wire logic [rfv_pkg::LIMIT_W-1:0] out_payload_length
);
  import rfv_pkg::*;

  // No result request may be pending right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request pending after reset");

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_MALFORMED) ||
                  (out_status == STATUS_CHECKSUM))
    else $error("undefined status code");

  // The reported length is clamped to the build maximum.
  a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({{(32 - LIMIT_W){1'b0}}, out_payload_length} <= 32'(MAX_PAYLOAD_BYTES)))
    else $error("payload length above the maximum");

  // A stalled result request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_sequence_res) && $stable(out_payload_length))
    else $error("stalled result changed");

endmodule

bind record_frame_validator rfv_checker #(
  .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
) u_rfv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_sequence_res   (out_sequence_res),
  .out_payload_length (out_payload_length)
);

`default_nettype wire

// ===== tb/record_frame_validator_test.sv =====
// Self-checking testbench for record_frame_validator: builds record frames byte by byte,
// predicts each status, sequence and length, and compares them with the block's results.
// Depends on rfv_pkg and record_frame_validator; needs no other file.
`default_nettype none

module record_frame_validator_test;

  localparam int unsigned MAX_PAYLOAD    = 4096;
  localparam int unsigned HDR_LEN        = 24;
  localparam logic [31:0] MAGIC_WORD     = 32'h5352_4631;
  localparam logic [15:0] REC_VER_WORD   = 16'd1;
  localparam logic [31:0] HASH_SEED      = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME     = 32'd16777619;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PHASE_BYTES    = 100;
  localparam int unsigned PHASE_FRAMES   = 3;
  localparam int unsigned RUN_LIMIT      = 400000;

  localparam logic [1:0] ST_OK    = rfv_pkg::STATUS_OK;
  localparam logic [1:0] ST_MALF  = rfv_pkg::STATUS_MALFORMED;
  localparam logic [1:0] ST_CHECK = rfv_pkg::STATUS_CHECKSUM;

  // Ways a frame can be built or damaged.
  typedef enum logic [3:0] {
    FK_GOOD,
    FK_BAD_MAGIC,
    FK_BAD_VERSION,
    FK_BAD_HSIZE,
    FK_OVER_LIMIT,
    FK_BAD_HDR_SUM,
    FK_BAD_PAY_SUM,
    FK_SHORT_HEADER,
    FK_SHORT_PAYLOAD,
    FK_NOISE
  } frame_kind_e;

  // Idle patterns of the two channels.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] seq;
    logic [12:0] plen;
  } frame_result_t;

  typedef struct packed {
    frame_kind_e   kind;
    logic [12:0]   plen;
    logic [31:0]   cut;
    logic [1:0]    tail;
    logic [31:0]   seq;
    logic          typed;
    frame_result_t want;
  } frame_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       in_data_byte = 8'd0;
  logic                             in_last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       out_status;
  logic [31:0]                      out_sequence_res;
  logic [rfv_pkg::LIMIT_W-1:0]      out_payload_length;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rfv_pkg::LIMIT_W-1:0]      cfg_payload_limit = '0;

  record_frame_validator #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_sequence_res  (out_sequence_res),
    .out_payload_length(out_payload_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_payload_limit (cfg_payload_limit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted record state, kept in step with accepted bytes.
  logic [12:0]   limit_setting;
  logic [13:0]   rec_count;
  logic [31:0]   rec_hdr_hash;
  logic [31:0]   rec_pay_hash;
  logic [31:0]   rec_seq;
  logic [31:0]   rec_len;
  logic [31:0]   rec_psum;
  logic [31:0]   rec_hsum;
  logic [31:0]   rec_magic;
  logic [15:0]   rec_version;
  logic [15:0]   rec_hsize;
  logic [1:0]    rec_status;

  frame_result_t pending_results[$];
  frame_result_t head_result;
  logic [7:0]    frame_q[$];
  int unsigned   in_gap_pct = 0;
  int unsigned   out_stall_pct = 0;
  int unsigned   fail_count = 0;

  // Directed frames, checked under the reset limit of 4096.
  frame_row_t directed_plan [0:20] = '{
    '{FK_SHORT_HEADER,  13'd0, 32'd1,  2'd0, 32'h0000_0000, 1'b1,
      '{ST_MALF, 32'h0, 13'd0}},
    '{FK_SHORT_HEADER,  13'd0, 32'd23, 2'd0, 32'hAAAA_5555, 1'b1,
      '{ST_MALF, 32'h0, 13'd0}},
    '{FK_GOOD,          13'd0, 32'd0,  2'd0, 32'h0000_0000, 1'b1,
      '{ST_OK, 32'h0, 13'd0}},
    '{FK_GOOD,          13'd1, 32'd0,  2'd0, 32'hFFFF_FFFF, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 13'd1}},
    '{FK_GOOD,          13'd5, 32'd0,  2'd0, 32'h1234_5678, 1'b1,
      '{ST_OK, 32'h1234_5678, 13'd5}},
    '{FK_BAD_MAGIC,     13'd2, 32'd0,  2'd0, 32'h7, 1'b1, '{ST_MALF, 32'h7, 13'd2}},
    '{FK_BAD_VERSION,   13'd0, 32'd0,  2'd0, 32'h8, 1'b1, '{ST_MALF, 32'h8, 13'd0}},
    '{FK_BAD_HSIZE,     13'd3, 32'd0,  2'd0, 32'h9, 1'b1, '{ST_MALF, 32'h9, 13'd3}},
    '{FK_OVER_LIMIT,    13'd2, 32'd0,  2'd0, 32'hA, 1'b1, '{ST_MALF, 32'hA, 13'd4096}},
    '{FK_OVER_LIMIT,    13'd0, 32'h7FFF_0000, 2'd0, 32'hA5, 1'b1,
      '{ST_MALF, 32'hA5, 13'd4096}},
    '{FK_BAD_HDR_SUM,   13'd4, 32'd0,  2'd0, 32'hB, 1'b1, '{ST_CHECK, 32'hB, 13'd4}},
    '{FK_BAD_PAY_SUM,   13'd0, 32'd0,  2'd0, 32'hC, 1'b1, '{ST_CHECK, 32'hC, 13'd0}},
    '{FK_BAD_PAY_SUM,   13'd6, 32'd0,  2'd0, 32'hD, 1'b1, '{ST_CHECK, 32'hD, 13'd6}},
    '{FK_SHORT_PAYLOAD, 13'd6, 32'd1,  2'd0, 32'hE, 1'b1, '{ST_MALF, 32'hE, 13'd6}},
    '{FK_SHORT_PAYLOAD, 13'd6, 32'd6,  2'd0, 32'hF, 1'b1, '{ST_MALF, 32'hF, 13'd6}},
    '{FK_GOOD,          13'd0, 32'd0,  2'd1, 32'h10, 1'b1, '{ST_MALF, 32'h10, 13'd0}},
    '{FK_GOOD,          13'd3, 32'd0,  2'd3, 32'h11, 1'b1, '{ST_MALF, 32'h11, 13'd3}},
    '{FK_BAD_HDR_SUM,   13'd2, 32'd0,  2'd2, 32'h12, 1'b1, '{ST_CHECK, 32'h12, 13'd2}},
    '{FK_BAD_PAY_SUM,   13'd3, 32'd0,  2'd1, 32'h13, 1'b1, '{ST_CHECK, 32'h13, 13'd3}},
    '{FK_GOOD,          13'd8, 32'd0,  2'd0, 32'h8000_0001, 1'b0, '0},
    '{FK_NOISE,         13'd30, 32'd0, 2'd0, 32'h0, 1'b0, '0}
  };

  // One FNV-1a step over a byte.
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] mixed;
    mixed = h ^ {24'd0, b};
    return mixed * HASH_PRIME;
  endfunction

  // Payload limit actually enforced: the register, capped by the build size.
  function automatic logic [31:0] limit_now();
    logic [31:0] lim;
    lim = {19'd0, limit_setting};
    if (lim > MAX_PAYLOAD) lim = MAX_PAYLOAD;
    return lim;
  endfunction

  task automatic clear_record();
    rec_count    = '0;
    rec_hdr_hash = HASH_SEED;
    rec_pay_hash = HASH_SEED;
    rec_seq      = '0;
    rec_len      = '0;
    rec_psum     = '0;
    rec_hsum     = '0;
    rec_magic    = '0;
    rec_version  = '0;
    rec_hsize    = '0;
    rec_status   = ST_OK;
  endtask

  // Advances the predicted record by one accepted byte; done is set when a result is due.
  task automatic track_record_byte(input logic [7:0] b, input logic l, output bit done,
                                   output frame_result_t res);
    logic [4:0]  idx;
    logic [31:0] put;
    logic [31:0] lim;
    logic [31:0] clamped;
    logic        hdr_done;
    done = 1'b0;
    res  = '0;
    lim  = limit_now();
    if (rec_count < HDR_LEN) begin
      // Header byte: hash it (checksum field as zero) and place it in its field.
      idx = rec_count[4:0];
      put = {24'd0, b} << (idx[1:0] * 8);
      rec_hdr_hash = fnv_mix(rec_hdr_hash, (idx >= 20) ? 8'd0 : b);
      case (idx[4:2])
        3'd0: rec_magic = rec_magic | put;
        3'd1: begin
          if (idx < 6) rec_version = rec_version | put[15:0];
          else rec_hsize = rec_hsize | (16'(b) << (idx[0] * 8));
        end
        3'd2: rec_seq = rec_seq | put;
        3'd3: rec_len = rec_len | put;
        3'd4: rec_psum = rec_psum | put;
        default: rec_hsum = rec_hsum | put;
      endcase
      rec_count = rec_count + 14'd1;
      if (rec_count == HDR_LEN && rec_status == ST_OK) begin
        if (rec_magic != MAGIC_WORD || rec_version != REC_VER_WORD ||
            rec_hsize != 16'(HDR_LEN) || rec_len > lim)
          rec_status = ST_MALF;
        else if (rec_hdr_hash != rec_hsum)
          rec_status = ST_CHECK;
        else if (rec_len == 0 && rec_pay_hash != rec_psum)
          rec_status = ST_CHECK;
      end
    end else if (rec_status == ST_OK) begin
      // Payload byte, or a trailing byte past the declared length.
      if (32'(rec_count) < HDR_LEN + rec_len) begin
        rec_pay_hash = fnv_mix(rec_pay_hash, b);
        rec_count = rec_count + 14'd1;
        if (32'(rec_count) == HDR_LEN + rec_len && rec_pay_hash != rec_psum)
          rec_status = ST_CHECK;
      end else begin
        rec_status = ST_MALF;
      end
    end

    if (l) begin
      hdr_done = (rec_count >= HDR_LEN);
      if (rec_status == ST_OK && (!hdr_done || 32'(rec_count) < HDR_LEN + rec_len))
        rec_status = ST_MALF;
      clamped    = (rec_len > lim) ? lim : rec_len;
      res.status = rec_status;
      res.seq    = hdr_done ? rec_seq : 32'd0;
      res.plen   = hdr_done ? clamped[12:0] : 13'd0;
      done       = 1'b1;
      clear_record();
    end
  endtask

  task automatic put_word(input int pos, input logic [31:0] val, input int nbytes);
    for (int k = 0; k < nbytes; k++) frame_q[pos + k] = val[8 * k +: 8];
  endtask

  function automatic logic [31:0] header_digest();
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < HDR_LEN; i++) h = fnv_mix(h, (i >= 20) ? 8'd0 : frame_q[i]);
    return h;
  endfunction

  function automatic logic [31:0] payload_digest();
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = HDR_LEN; i < frame_q.size(); i++) h = fnv_mix(h, frame_q[i]);
    return h;
  endfunction

  function automatic logic [7:0] one_bit();
    return 8'd1 << $urandom_range(7);
  endfunction

  // Builds one frame into frame_q: a well-formed record, then the damage that kind asks.
  task automatic build_frame(input frame_kind_e kind, input int unsigned plen,
                             input logic [31:0] cut, input int unsigned tail,
                             input logic [31:0] seq);
    logic [31:0] declared;
    int          pos;
    frame_q.delete();
    if (kind == FK_NOISE) begin
      repeat (plen) frame_q.push_back(8'($urandom));
      return;
    end
    repeat (HDR_LEN) frame_q.push_back(8'd0);
    declared = plen;
    if (kind == FK_OVER_LIMIT) begin
      declared = limit_now() + 32'd1 + cut;
      if (declared <= limit_now()) declared = 32'hFFFF_FFFF;
    end
    put_word(0, MAGIC_WORD, 4);
    put_word(4, {16'd0, REC_VER_WORD}, 2);
    put_word(6, HDR_LEN, 2);
    put_word(8, seq, 4);
    put_word(12, declared, 4);
    repeat (plen) frame_q.push_back(8'($urandom));
    put_word(16, payload_digest(), 4);

    // Damage that the header checksum must still cover.
    case (kind)
      FK_BAD_MAGIC: begin
        pos = $urandom_range(3);
        frame_q[pos] = frame_q[pos] ^ one_bit();
      end
      FK_BAD_VERSION: begin
        pos = 4 + $urandom_range(1);
        frame_q[pos] = frame_q[pos] ^ one_bit();
      end
      FK_BAD_HSIZE: begin
        pos = 6 + $urandom_range(1);
        frame_q[pos] = frame_q[pos] ^ one_bit();
      end
      FK_BAD_PAY_SUM: begin
        if (plen == 0) begin
          pos = 16 + $urandom_range(3);
          frame_q[pos] = frame_q[pos] ^ one_bit();
        end
      end
      default: ;
    endcase
    put_word(20, header_digest(), 4);

    // Damage applied after both checksums are in place.
    case (kind)
      FK_BAD_HDR_SUM: begin
        pos = 20 + $urandom_range(3);
        frame_q[pos] = frame_q[pos] ^ one_bit();
      end
      FK_BAD_PAY_SUM: begin
        if (plen != 0) begin
          pos = HDR_LEN + $urandom_range(plen - 1);
          frame_q[pos] = frame_q[pos] ^ one_bit();
        end
      end
      FK_SHORT_HEADER: begin
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      FK_SHORT_PAYLOAD: begin
        repeat (cut) void'(frame_q.pop_back());
      end
      default: ;
    endcase
    repeat (tail) frame_q.push_back(8'($urandom));
  endtask

  // Offers one byte request, with a random gap first, and predicts on acceptance.
  task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                           input frame_result_t want);
    bit            done;
    frame_result_t predicted;
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    do @(posedge clk); while (!in_ready);
    track_record_byte(b, l, done, predicted);
    if (done) pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_frame(input bit typed, input frame_result_t want);
    for (int i = 0; i < frame_q.size(); i++)
      push_byte(frame_q[i], i == frame_q.size() - 1, typed, want);
  endtask

  // Lets the block go quiet: all results in, then an idle settling wait.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [12:0] value);
    cfg_valid         <= 1'b1;
    cfg_payload_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    limit_setting = value;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin in_gap_pct = 0;  out_stall_pct = 0;  end
      IDLE_SENDER:   begin in_gap_pct = 47; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_gap_pct = 0;  out_stall_pct = 47; end
      default:       begin in_gap_pct = 35; out_stall_pct = 35; end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch in %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  // Random frame: mostly well formed, with every kind of damage mixed in.
  task automatic random_frame();
    frame_kind_e kind;
    int unsigned plen;
    logic [31:0] cut;
    int unsigned tail;
    if ($urandom_range(99) < 55) kind = FK_GOOD;
    else kind = frame_kind_e'($urandom_range(FK_BAD_MAGIC, FK_NOISE));
    plen = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(12);
    cut  = 0;
    if (kind != FK_OVER_LIMIT && kind != FK_NOISE && plen > limit_now()) plen = limit_now();
    if (kind == FK_SHORT_PAYLOAD && plen == 0) begin
      if (limit_now() == 0) kind = FK_SHORT_HEADER;
      else plen = 1;
    end
    case (kind)
      FK_SHORT_HEADER:  cut = $urandom_range(1, HDR_LEN - 1);
      FK_SHORT_PAYLOAD: cut = $urandom_range(1, plen);
      FK_OVER_LIMIT:    cut = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4);
      FK_NOISE:         plen = $urandom_range(1, 40);
      default: ;
    endcase
    tail = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    build_frame(kind, plen, cut, tail, $urandom);
    send_frame(1'b0, '0);
  endtask

  // Receiver side: random stalls on the result channel.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result status", 32'(out_status), 32'hX);
      end else begin
        head_result = pending_results.pop_front();
        if (out_status != head_result.status)
          note_mismatch("status", 32'(out_status), 32'(head_result.status));
        if (out_sequence_res != head_result.seq)
          note_mismatch("sequence", out_sequence_res, head_result.seq);
        if (out_payload_length != head_result.plen)
          note_mismatch("payload length", 32'(out_payload_length), 32'(head_result.plen));
      end
    end
  end

  // Main sequence: reset, directed frames, then random phases over limits and idling.
  initial begin
    int unsigned sent;
    int unsigned frames;
    limit_setting = 13'd4096;
    clear_record();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(IDLE_NONE);
    for (int r = 0; r < $size(directed_plan); r++) begin
      build_frame(directed_plan[r].kind, directed_plan[r].plen, directed_plan[r].cut,
                  directed_plan[r].tail, directed_plan[r].seq);
      send_frame(directed_plan[r].typed, directed_plan[r].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: write_limit(13'd0);
          2: write_limit(13'd8191);
          3: write_limit(13'($urandom_range(1, 40)));
          4: write_limit(13'd4096);
          5: write_limit(13'($urandom_range(0, 8191)));
          6: write_limit(13'd1);
          default: write_limit(13'($urandom_range(1, 40)));
        endcase
      end
      set_idle(idle_mode_e'(ph % 4));
      sent   = 0;
      frames = 0;
      while (sent < PHASE_BYTES || frames < PHASE_FRAMES) begin
        random_frame();
        sent   += frame_q.size();
        frames += 1;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a result that never comes.
  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
